@@ src/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRGS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");

// Condition must never be seen outside reset.
`define PRGS_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("%m: forbidden condition");

`endif

@@ src/prgs_pkg.sv @@
// Shared constants and types of the point row group sorter.
package prgs_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 12;
	localparam int IDX_BITS   = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);

	// port field widths
	localparam int X_W   = 12;
	localparam int Y_W   = 12;
	localparam int ROW_W = 6;

	typedef struct packed {
		logic [IDX_BITS-1:0]   row;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} entry_t;

	// payload of the lookup stage
	typedef struct packed {
		logic   keep;
		logic   fin;
		logic   ovf;
		entry_t e;
	} s1_t;

	typedef struct packed {
		logic ins;
		logic shl;
	} cell_ctl_t;

	// head of the chain, as seen by the output register
	typedef struct packed {
		logic   valid;
		entry_t e;
		logic   row_end;
		logic   list_end;
		logic   overflow;
	} head_t;

endpackage

@@ src/point_row_group_sort.sv @@
// Top level of the point row group sorter.
// Usage:
//  - Input stream: one point per word, tdata = {y, x}; tlast marks the final point of a list.
//    Words are taken one per cycle while tready is high.
//  - Each point's y is looked up among the row keys seen so far in this list and the result registered,
//    then the point is inserted into a chain of MAX_POINTS cells ordered by row, then x.
//    Points past capacity are dropped and the overflow flag is raised for the list.
//  - After the final word is taken, tready stays low while the list drains. The first
//    result word follows the final word through the lookup register and the chain into the
//    output register; after that one result word leaves per cycle while m_axis_tready is high.
//  - Output stream: tdata = {y, x, row}, tuser = {overflow, row_end}, tlast on the last
//    point of the list.
//  - A receiver stall freezes the output register and the chain; nothing is lost.
//  - tready returns high in the cycle after the tlast result word is taken.
//  - Reset clears all counts and flags; the chain contents need no reset.
module point_row_group_sort (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [11:0] point_x, [23:12] point_y
	input  logic        s_axis_tlast,  // final_point
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [5:0] row_number, [17:6] out_x, [29:18] out_y, zero pad
	output logic [1:0]  m_axis_tuser,  // [0] row_end, [1] overflow
	output logic        m_axis_tlast   // list_end
);

	logic                            busy_q;
	logic                            acc_in;
	logic [prgs_pkg::COORD_BITS-1:0] in_x;
	logic [prgs_pkg::COORD_BITS-1:0] in_y;
	logic                            s1_valid;
	prgs_pkg::s1_t                   s1;
	prgs_pkg::head_t                 head;
	logic                            pop;
	logic                            out_vld_q;
	logic [31:0]                     data_q;
	logic [1:0]                      user_q;
	logic                            last_q;

	// input side closes from the final word until the list has fully left
	assign s_axis_tready = !busy_q;
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign in_x = prgs_pkg::COORD_BITS'(s_axis_tdata[prgs_pkg::X_W-1:0]);
	assign in_y = prgs_pkg::COORD_BITS'(s_axis_tdata[prgs_pkg::X_W +: prgs_pkg::Y_W]);

	prgs_row_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (acc_in),
		.x        (in_x),
		.y        (in_y),
		.fin      (s_axis_tlast),
		.s1_valid (s1_valid),
		.s1       (s1)
	);

	prgs_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s1_valid),
		.in       (s1),
		.pop      (pop),
		.head     (head)
	);

	// head moves to the output register whenever that register is free or emptying
	assign pop = head.valid && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc_in && s_axis_tlast) begin
				busy_q <= 1'b1;
			end else if (out_vld_q && m_axis_tready && last_q) begin
				busy_q <= 1'b0;
			end
			if (pop) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {2'b00,
				prgs_pkg::Y_W'(head.e.y),
				prgs_pkg::X_W'(head.e.x),
				prgs_pkg::ROW_W'(head.e.row)};
			user_q <= {head.overflow, head.row_end};
			last_q <= head.list_end;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = last_q;

endmodule

@@ src/prgs_row_lookup.sv @@
// Row key lookup stage: maps y to a row number and admits or drops each point.
module prgs_row_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [prgs_pkg::COORD_BITS-1:0] x,
	input  logic [prgs_pkg::COORD_BITS-1:0] y,
	input  logic                            fin,
	output logic                            s1_valid,
	output prgs_pkg::s1_t                   s1
);

	logic [prgs_pkg::COORD_BITS-1:0] key_q [prgs_pkg::MAX_POINTS];
	logic [prgs_pkg::CNT_BITS-1:0]   rcnt_q;
	logic [prgs_pkg::CNT_BITS-1:0]   pcnt_q;
	logic                            drop_q;
	logic [prgs_pkg::MAX_POINTS-1:0] match;
	logic [prgs_pkg::IDX_BITS-1:0]   hit_row;
	logic                            hit;
	logic                            full;
	logic                            keep;
	logic                            vld_s1;
	prgs_pkg::s1_t                   pay_s1;

	// at most one live key matches, so an OR of indexes encodes it
	always_comb begin
		hit_row = '0;
		for (int i = 0; i < prgs_pkg::MAX_POINTS; i++) begin
			match[i] = (prgs_pkg::CNT_BITS'(i) < rcnt_q) && (key_q[i] == y);
			if (match[i]) begin
				hit_row = hit_row | prgs_pkg::IDX_BITS'(i);
			end
		end
	end

	assign hit  = |match;
	assign full = (pcnt_q == prgs_pkg::CNT_BITS'(prgs_pkg::MAX_POINTS));
	assign keep = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			pcnt_q <= '0;
			drop_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				if (fin) begin
					rcnt_q <= '0;
					pcnt_q <= '0;
					drop_q <= 1'b0;
				end else if (keep) begin
					pcnt_q <= pcnt_q + 1'b1;
					if (!hit) begin
						rcnt_q <= rcnt_q + 1'b1;
					end
				end else begin
					drop_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep && !hit) begin
			key_q[rcnt_q[prgs_pkg::IDX_BITS-1:0]] <= y;
		end
		if (accept) begin
			pay_s1.keep  <= keep;
			pay_s1.fin   <= fin;
			pay_s1.ovf   <= drop_q | full;
			pay_s1.e.row <= hit ? hit_row : rcnt_q[prgs_pkg::IDX_BITS-1:0];
			pay_s1.e.x   <= x;
			pay_s1.e.y   <= y;
		end
	end

	assign s1_valid = vld_s1;
	assign s1       = pay_s1;

endmodule

@@ src/prgs_cell.sv @@
// One insertion cell: holds one sorted point and trades it with its neighbors.
module prgs_cell (
	input  logic                clk,
	input  prgs_pkg::cell_ctl_t ctl,
	input  logic                occ,
	input  logic                take_prev,
	input  prgs_pkg::entry_t    new_e,
	input  prgs_pkg::entry_t    left_e,
	input  prgs_pkg::entry_t    right_e,
	output prgs_pkg::entry_t    ent,
	output logic                take
);

	prgs_pkg::entry_t ent_q;
	logic             greater;

	// strict compare keeps equal points in arrival order
	assign greater = occ && ((ent_q.row > new_e.row) ||
		((ent_q.row == new_e.row) && (ent_q.x > new_e.x)));
	assign take = !occ || greater;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (take_prev) begin
				ent_q <= left_e;
			end else if (take) begin
				ent_q <= new_e;
			end
		end else if (ctl.shl) begin
			ent_q <= right_e;
		end
	end

	assign ent = ent_q;

endmodule

@@ src/prgs_chain.sv @@
// Sorting chain: a row of cells filled by insertion and emptied from the head.
module prgs_chain (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  prgs_pkg::s1_t    in,
	input  logic             pop,
	output prgs_pkg::head_t  head
);

	logic [prgs_pkg::CNT_BITS-1:0]   cnt_q;
	logic                            drain_q;
	logic                            ovf_q;
	prgs_pkg::entry_t                ent     [prgs_pkg::MAX_POINTS];
	prgs_pkg::entry_t                left_e  [prgs_pkg::MAX_POINTS];
	prgs_pkg::entry_t                right_e [prgs_pkg::MAX_POINTS];
	logic [prgs_pkg::MAX_POINTS-1:0] take;
	logic [prgs_pkg::MAX_POINTS-1:0] take_prev;
	logic [prgs_pkg::MAX_POINTS-1:0] occ;
	prgs_pkg::cell_ctl_t             ctl;
	logic                            last_one;

	assign ctl.ins   = in_valid && in.keep;
	assign ctl.shl   = pop;
	assign take_prev = {take[prgs_pkg::MAX_POINTS-2:0], 1'b0};

	always_comb begin
		for (int i = 0; i < prgs_pkg::MAX_POINTS; i++) begin
			occ[i]     = prgs_pkg::CNT_BITS'(i) < cnt_q;
			left_e[i]  = (i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1];
			right_e[i] = (i == prgs_pkg::MAX_POINTS - 1) ? '0 :
				ent[(i == prgs_pkg::MAX_POINTS - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < prgs_pkg::MAX_POINTS; g++) begin : g_cell
		prgs_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ[g]),
			.take_prev (take_prev[g]),
			.new_e     (in.e),
			.left_e    (left_e[g]),
			.right_e   (right_e[g]),
			.ent       (ent[g]),
			.take      (take[g])
		);
	end

	assign last_one = (cnt_q == prgs_pkg::CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (in_valid) begin
			if (in.keep) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (in.fin) begin
				drain_q <= 1'b1;
				ovf_q   <= in.ovf;
			end
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
			if (last_one) begin
				drain_q <= 1'b0;
			end
		end
	end

	assign head.valid    = drain_q;
	assign head.e        = ent[0];
	assign head.list_end = last_one;
	assign head.row_end  = last_one || (ent[1].row != ent[0].row);
	assign head.overflow = ovf_q;

endmodule

@@ src/prgs_checker.sv @@
// Port-level checker for the point row group sorter, bound to the top level.
`include "assert_macros.svh"

module prgs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled result word holds
	`PRGS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	// the final point closes the input side
	`PRGS_ASSERT(a_in_close, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
	// taking the last result word reopens the input side
	`PRGS_ASSERT(a_in_reopen, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
	// the last point of a list always ends its row
	`PRGS_NEVER(a_end_row, m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0])
	// results appear only while input is closed
	`PRGS_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid)

endmodule

bind point_row_group_sort prgs_checker u_prgs_checker (.*);

@@ sim/point_row_group_sort_tb.sv @@
// Self-checking testbench for the point row group sorter.
`timescale 1ns / 1ps

module point_row_group_sort_tb;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 6;
	localparam int LONG_HOLD    = 150;   // receiver hold-off, in cycles
	localparam int SETTLE       = 4;     // quiet cycles before a sender pause ends
	localparam int DRAIN_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 10;

	// one point offered on the input stream
	typedef struct {
		logic [prgs_pkg::X_W-1:0] x;
		logic [prgs_pkg::Y_W-1:0] y;
		logic                     fin;
		logic                     hold;  // wait for the previous list to drain first
	} point_word_t;

	// one stored point of the sorted list
	typedef struct packed {
		logic [prgs_pkg::ROW_W-1:0] row;
		logic [prgs_pkg::X_W-1:0]   x;
		logic [prgs_pkg::Y_W-1:0]   y;
	} sorted_pt_t;

	// one expected output word
	typedef struct packed {
		sorted_pt_t p;
		logic       row_end;
		logic       list_end;
		logic       ovf;
	} sorted_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [11:0] point_x, [23:12] point_y
	logic        s_axis_tlast = 1'b0; // final_point
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [5:0] row_number, [17:6] out_x, [29:18] out_y
	logic [1:0]  m_axis_tuser;        // [0] row_end, [1] overflow
	logic        m_axis_tlast;        // list_end

	point_row_group_sort dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	point_word_t  pending_points[$];   // words still to be offered
	sorted_word_t sorted_due[$];       // output words still to arrive

	int  errors        = 0;
	int  words_checked = 0;
	int  lists_done    = 0;            // lists whose tlast word has left
	int  lists_sent    = 0;
	int  points_sent   = 0;
	int  ovf_lists     = 0;
	int  long_holds    = 0;
	int  quiet_cnt     = 0;            // cycles with nothing expected
	logic in_took = 1'b0;              // input word accepted at the last rising edge

	// stimulus list tracking, used while the queue is filled
	int list_idx       = 0;
	int words_in_list  = 0;

	// ------------------------------------------------------------------
	// Predictor: rows by first appearance of y, points by ascending x
	// inside a row, new points placed after equal ones.
	// ------------------------------------------------------------------
	logic [prgs_pkg::Y_W-1:0] row_key [prgs_pkg::MAX_POINTS];
	int                       row_cnt = 0;
	sorted_pt_t               sorted_store [prgs_pkg::MAX_POINTS];
	int                       held_cnt = 0;
	logic                     dropped = 1'b0;

	task automatic sort_point(input logic [prgs_pkg::X_W-1:0] x,
			input logic [prgs_pkg::Y_W-1:0] y, input logic fin);
		int           r;
		int           pos;
		bit           keep;
		sorted_word_t w;
		keep = 1'b1;
		if (held_cnt >= prgs_pkg::MAX_POINTS) begin
			dropped = 1'b1;
			keep    = 1'b0;
		end
		if (keep) begin
			r = row_cnt;
			for (int i = 0; i < row_cnt; i++) begin
				if (r == row_cnt && row_key[i] == y)
					r = i;
			end
			if (r == row_cnt) begin
				if (row_cnt >= prgs_pkg::MAX_POINTS) begin
					dropped = 1'b1;
					keep    = 1'b0;
				end else begin
					row_key[row_cnt] = y;
					row_cnt++;
				end
			end
		end
		if (keep) begin
			pos = held_cnt;
			for (int i = 0; i < held_cnt; i++) begin
				if (pos == held_cnt && (sorted_store[i].row > r ||
						(sorted_store[i].row == r && sorted_store[i].x > x)))
					pos = i;
			end
			for (int i = held_cnt; i > pos; i--)
				sorted_store[i] = sorted_store[i-1];
			sorted_store[pos].row = r[prgs_pkg::ROW_W-1:0];
			sorted_store[pos].x   = x;
			sorted_store[pos].y   = y;
			held_cnt++;
		end
		if (fin) begin
			// whole list leaves at once; counts clear for the next list
			for (int k = 0; k < held_cnt; k++) begin
				w.p        = sorted_store[k];
				w.list_end = (k == held_cnt - 1);
				w.row_end  = w.list_end || (sorted_store[k+1].row != sorted_store[k].row);
				w.ovf      = dropped;
				sorted_due.insert(sorted_due.size(), w);
			end
			if (dropped)
				ovf_lists++;
			lists_sent++;
			row_cnt  = 0;
			held_cnt = 0;
			dropped  = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_point(input int x, input int y, input bit fin);
		point_word_t w;
		w.x    = x[prgs_pkg::X_W-1:0];
		w.y    = y[prgs_pkg::Y_W-1:0];
		w.fin  = fin;
		// every seventh list, counting from the fourth, waits for a full drain
		w.hold = (words_in_list == 0) && (list_idx % 7 == 3);
		pending_points.insert(pending_points.size(), w);
		if (fin) begin
			list_idx++;
			words_in_list = 0;
		end else begin
			words_in_list++;
		end
	endtask

	// random list: y drawn from a small pool (few wide rows) or from the full
	// range (many short rows); x often narrow so that duplicates show up
	task automatic add_random_list(input int n);
		int ypool [4];
		int npool;
		int ystyle;
		int x;
		int y;
		npool  = $urandom_range(1, 4);
		ystyle = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 5))
				0: ypool[i] = 0;
				1: ypool[i] = (1 << prgs_pkg::Y_W) - 1;
				default: ypool[i] = $urandom_range(0, (1 << prgs_pkg::Y_W) - 1);
			endcase
		end
		for (int i = 0; i < n; i++) begin
			if (ystyle == 0)
				y = $urandom_range(0, (1 << prgs_pkg::Y_W) - 1);
			else
				y = ypool[$urandom_range(0, npool - 1)];
			if ($urandom_range(0, 3) == 0)
				x = $urandom_range(0, 7);
			else
				x = $urandom_range(0, (1 << prgs_pkg::X_W) - 1);
			add_point(x, y, i == n - 1);
		end
	endtask

	// ------------------------------------------------------------------
	// Input driver: bursts of words with random gaps, changes at the
	// falling edge. A word marked hold is held back until the previous
	// list has drained completely.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin : drive_points
		point_word_t w;
		if (arst_n) begin
			if (!s_axis_tvalid || in_took) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_points.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (pending_points[0].hold &&
						(sorted_due.size() != 0 || quiet_cnt < SETTLE)) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					w = pending_points.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {w.y, w.x};
					s_axis_tlast  <= w.fin;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output receiver: stall mode is redrawn at random as the run goes on; on some lists
	// it holds off for a long stretch at the first output word, while the
	// driver keeps offering the next list.
	// ------------------------------------------------------------------
	int rx_cyc    = 0;
	int rx_mode   = 0;
	int hold_left = 0;
	int held_list = -1;

	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			rx_cyc++;
			if (rx_cyc % 50 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (m_axis_tvalid && lists_done % 6 == 1 && held_list != lists_done) begin
				held_list = lists_done;
				hold_left = LONG_HOLD;
				long_holds++;
				m_axis_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= rx_cyc[2] ^ rx_cyc[0];
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: feeds accepted input words to the predictor and checks
	// every output word against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_streams
		sorted_word_t want;
		if (arst_n) begin
			in_took <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				points_sent++;
				sort_point(s_axis_tdata[11:0], s_axis_tdata[23:12], s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (m_axis_tlast)
					lists_done++;
				if (sorted_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected output word, tdata %h tuser %b tlast %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = sorted_due.pop_front();
					words_checked++;
					if (m_axis_tdata[5:0] !== want.p.row) begin
						errors++;
						$display("%0t: row_number expected %0d actual %0d",
							$time, want.p.row, m_axis_tdata[5:0]);
					end
					if (m_axis_tdata[17:6] !== want.p.x) begin
						errors++;
						$display("%0t: out_x expected %h actual %h",
							$time, want.p.x, m_axis_tdata[17:6]);
					end
					if (m_axis_tdata[29:18] !== want.p.y) begin
						errors++;
						$display("%0t: out_y expected %h actual %h",
							$time, want.p.y, m_axis_tdata[29:18]);
					end
					if (m_axis_tuser[0] !== want.row_end) begin
						errors++;
						$display("%0t: row_end expected %b actual %b",
							$time, want.row_end, m_axis_tuser[0]);
					end
					if (m_axis_tlast !== want.list_end) begin
						errors++;
						$display("%0t: list_end expected %b actual %b",
							$time, want.list_end, m_axis_tlast);
					end
					if (m_axis_tuser[1] !== want.ovf) begin
						errors++;
						$display("%0t: overflow expected %b actual %b",
							$time, want.ovf, m_axis_tuser[1]);
					end
				end
			end
			if (sorted_due.size() == 0)
				quiet_cnt <= quiet_cnt + 1;
			else
				quiet_cnt <= 0;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : run_main
		int n;
		int drain_wait;
		int pick;

		// directed: single point at the low corner
		add_point(0, 0, 1);
		// corners, a duplicate point, neighbors around the midpoint
		add_point(4095, 4095, 0);
		add_point(0, 4095, 0);
		add_point(4095, 0, 0);
		add_point(0, 0, 0);
		add_point(4095, 4095, 0);
		add_point(2048, 2047, 0);
		add_point(2047, 2048, 0);
		add_point(1365, 2730, 1);
		// one row, x arriving out of order with duplicates
		add_point(9, 100, 0);
		add_point(3, 100, 0);
		add_point(9, 100, 0);
		add_point(3, 100, 0);
		add_point(0, 100, 0);
		add_point(4095, 100, 1);
		// row order follows first appearance of y, not its value
		add_point(700, 50, 0);
		add_point(20, 10, 0);
		add_point(5, 50, 0);
		add_point(300, 30, 1);

		// random lists: one past capacity (final two points dropped), one exactly
		// full, then mostly short lists with a few long ones
		add_random_list(prgs_pkg::MAX_POINTS + 2);
		add_random_list(prgs_pkg::MAX_POINTS);
		while (pending_points.size() < 430) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				n = $urandom_range(1, 10);
			else if (pick < 17)
				n = $urandom_range(11, 40);
			else if (pick < 19)
				n = $urandom_range(41, prgs_pkg::MAX_POINTS);
			else
				n = $urandom_range(prgs_pkg::MAX_POINTS + 1, prgs_pkg::MAX_POINTS + 8);
			add_random_list(n);
		end

		// reset
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all words offered and taken
		do @(posedge clk); while (pending_points.size() != 0 || s_axis_tvalid);

		// every expected word in, then a quiet tail for stray words
		drain_wait = 0;
		while (sorted_due.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		if (sorted_due.size() != 0) begin
			errors++;
			$display("%0t: %0d output words never arrived", $time, sorted_due.size());
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sorted %0d lists from %0d points, %0d output words checked.",
			lists_sent, points_sent, words_checked);
		$display("%0d lists overflowed; receiver held off %0d times for %0d cycles.",
			ovf_lists, long_holds, LONG_HOLD);
		if (errors == 0)
			$display("** point_row_group_sort: PASSED **");
		else
			$display("** point_row_group_sort: FAILED **");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin : watchdog
		#10ms;
		$display("%0t: timeout", $time);
		$display("** point_row_group_sort: FAILED **");
		$finish;
	end

endmodule
